// ----- hw/rtl/per_port_token_bucket_table_top_macros.svh -----
// ----------------------------------------------------------------------------
// Token bucket table assertion macros
// Concurrent assertion helpers on clk_i with rst_ni as the disable condition.
// ----------------------------------------------------------------------------
`ifndef PER_PORT_TOKEN_BUCKET_TABLE_TOP_MACROS_SVH
`define PER_PORT_TOKEN_BUCKET_TABLE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define PPTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PPTB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PPTB_ASSERT(lbl, prop, msg)
`define PPTB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- hw/rtl/pptb_pkg.sv -----
// ----------------------------------------------------------------------------
// Token bucket table package
// Field widths, request codes, defaults and the slot table entry type.
// ----------------------------------------------------------------------------
package pptb_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 8;

  localparam int CAP_W  = 16;
  localparam int SLOT_W = 6;
  localparam int AMT_W  = 24;
  localparam int BAL_W  = 32;
  localparam int REQ_W  = 2;

  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CONSUME = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SETNEED = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP     = 2'd3;

  localparam logic [BAL_W-1:0] BAL_MAX = 32'h7FFF_FFFF;
  localparam logic [BAL_W-1:0] BAL_MIN = 32'h8000_0000;

  typedef struct packed {
    logic             active;
    logic [AMT_W-1:0] need;
    logic [BAL_W-1:0] bal;
  } entry_t;

endpackage

// ----- hw/rtl/per_port_token_bucket_table_top.sv -----
// ----------------------------------------------------------------------------
// Per-port token bucket table
// One token bucket per port slot, kept in a single RAM and walked by a
// small sequencer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot RAM with busy high. A consume,
// set-need or no-op word is accepted on start while busy is low, reads
// its slot from the RAM, is handled in S_ITEM, and its result appears
// with result_valid_o as the block returns to idle; a new word is taken
// only once the last one has finished. A tick walks every slot through
// one shared add/compare unit, one slot per cycle.
// Each result is shown for one cycle only and cannot be held off, so the
// receiver must take it when result_valid_o is high. Capacity may be
// written on the cfg channel at any time the block is idle.
module per_port_token_bucket_table_top #(
  parameter int NUM_SLOTS = pptb_pkg::NUM_SLOTS_DEF,
  parameter int FRAC_BITS = pptb_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pptb_pkg::CAP_W-1:0]  cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [pptb_pkg::REQ_W-1:0]  req_type_i,
  input  logic [pptb_pkg::SLOT_W-1:0] slot_i,
  input  logic [pptb_pkg::AMT_W-1:0]  amount_i,
  input  logic [pptb_pkg::AMT_W-1:0]  need_value_i,
  output logic                        result_valid_o,
  output logic                        send_request_o,
  output logic                        left_capacity_o,
  output logic                        at_capacity_o,
  output logic signed [pptb_pkg::BAL_W-1:0] balance_o
);

  localparam int AW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int XW      = AW + pptb_pkg::SLOT_W;
  localparam int ENTRY_W = $bits(pptb_pkg::entry_t);
  localparam int CW      = pptb_pkg::CAP_W + 32;
  localparam logic [32:0]   ONE_X = 33'(1) << FRAC_BITS;
  localparam logic [AW-1:0] LAST  = AW'(NUM_SLOTS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_ITEM  = 3'd3;

  logic [2:0]                  state_q, state_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [pptb_pkg::CAP_W-1:0]  cap_q;
  logic [pptb_pkg::REQ_W-1:0]  req_q;
  logic [AW-1:0]               saddr_q;
  logic                        sok_q;
  logic [pptb_pkg::AMT_W-1:0]  amt_q;
  logic [pptb_pkg::AMT_W-1:0]  need_q;
  logic                        grew_q, grew_d;
  logic                        sendacc_q, sendacc_d;
  logic [pptb_pkg::BAL_W-1:0]  tbal_q, tbal_d;
  logic                        full_q, full_d;
  logic                        rvalid_q, rvalid_d;
  logic                        send_q, send_d;
  logic                        left_q, left_d;
  logic [pptb_pkg::BAL_W-1:0]  bal_q, bal_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  pptb_pkg::entry_t      ram_wdata;
  pptb_pkg::entry_t      ent;
  logic [ENTRY_W-1:0]    ram_rdata;

  logic [XW-1:0]              slot_x;
  logic [AW-1:0]              slot_addr;
  logic                       slot_ok;
  logic                       accept;
  logic [CW-1:0]              cap_w;
  logic [pptb_pkg::BAL_W-1:0] cap_sat;
  logic                       cap_lt;
  logic [32:0]                inc_sum;
  logic [pptb_pkg::BAL_W-1:0] inc_bal;
  logic [pptb_pkg::BAL_W-1:0] tick_bal;
  logic                       need_met;
  logic [pptb_pkg::BAL_W-1:0] cons_base;
  logic [32:0]                dif;
  logic [pptb_pkg::BAL_W-1:0] cons_bal;

  pptb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent = pptb_pkg::entry_t'(ram_rdata);

  assign slot_x    = XW'(slot_i);
  assign slot_addr = slot_x[AW-1:0];
  assign slot_ok   = slot_x < XW'(NUM_SLOTS);
  assign accept    = start && !busy;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Capacity in fixed point, clamped to the largest balance.
  assign cap_w   = CW'(cap_q) << FRAC_BITS;
  assign cap_sat = (cap_w[CW-1:31] != '0) ? pptb_pkg::BAL_MAX : cap_w[31:0];

  // Shared arithmetic: one saturating add for a tick, one saturating
  // subtract for a consume.
  assign cap_lt   = $signed({{(CW - 31){ent.bal[31]}}, ent.bal}) < $signed({1'b0, cap_w});
  assign inc_sum  = {ent.bal[31], ent.bal} + ONE_X;
  assign inc_bal  = (inc_sum[32] != inc_sum[31]) ? pptb_pkg::BAL_MAX : inc_sum[31:0];
  assign tick_bal = cap_lt ? inc_bal : ent.bal;
  assign need_met = (ent.need != '0) &&
                    ($signed({tick_bal[31], tick_bal}) >= $signed({9'b0, ent.need}));

  assign cons_base = ent.active ? ent.bal : cap_sat;
  assign dif       = {cons_base[31], cons_base} - {9'b0, amt_q};
  assign cons_bal  = (dif[32] != dif[31]) ? pptb_pkg::BAL_MIN : dif[31:0];

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    grew_d    = grew_q;
    sendacc_d = sendacc_q;
    tbal_d    = tbal_q;
    full_d    = full_q;
    rvalid_d  = 1'b0;
    send_d    = send_q;
    left_d    = left_q;
    bal_d     = bal_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        idx_d  = AW'(idx_q + 1'b1);
        if (idx_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = slot_addr;
        if (accept) begin
          if (req_type_i == pptb_pkg::REQ_TICK) begin
            ram_raddr = '0;
            idx_d     = '0;
            grew_d    = 1'b0;
            sendacc_d = 1'b0;
            tbal_d    = '0;
            state_d   = S_TICK;
          end else begin
            state_d = S_ITEM;
          end
        end
      end
      S_TICK: begin
        ram_raddr = AW'(idx_q + 1'b1);
        ram_waddr = idx_q;
        ram_wdata = '{active: 1'b1, need: ent.need, bal: tick_bal};
        if (ent.active) begin
          ram_we = cap_lt;
          if (cap_lt) begin
            grew_d = 1'b1;
          end
          if (need_met) begin
            sendacc_d = 1'b1;
          end
        end
        if (sok_q && (idx_q == saddr_q)) begin
          tbal_d = ent.active ? tick_bal : '0;
        end
        idx_d = AW'(idx_q + 1'b1);
        if (idx_q == LAST) begin
          state_d  = S_IDLE;
          rvalid_d = 1'b1;
          full_d   = !grew_d;
          send_d   = sendacc_d;
          left_d   = 1'b0;
          bal_d    = tbal_d;
        end
      end
      S_ITEM: begin
        ram_waddr = saddr_q;
        state_d   = S_IDLE;
        rvalid_d  = 1'b1;
        send_d    = 1'b0;
        left_d    = 1'b0;
        bal_d     = (sok_q && ent.active) ? ent.bal : '0;
        if (sok_q && (req_q == pptb_pkg::REQ_CONSUME)) begin
          ram_we    = 1'b1;
          ram_wdata = '{active: 1'b1, need: ent.need, bal: cons_bal};
          bal_d     = cons_bal;
          left_d    = full_q;
          full_d    = 1'b0;
        end else if (sok_q && (req_q == pptb_pkg::REQ_SETNEED)) begin
          ram_we    = 1'b1;
          ram_wdata = '{active: ent.active, need: need_q, bal: ent.bal};
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      cap_q     <= '0;
      full_q    <= 1'b0;
      rvalid_q  <= 1'b0;
      grew_q    <= 1'b0;
      sendacc_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      full_q    <= full_d;
      rvalid_q  <= rvalid_d;
      grew_q    <= grew_d;
      sendacc_q <= sendacc_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      saddr_q <= slot_addr;
      sok_q   <= slot_ok;
      amt_q   <= amount_i;
      need_q  <= need_value_i;
    end
    tbal_q <= tbal_d;
    send_q <= send_d;
    left_q <= left_d;
    bal_q  <= bal_d;
  end

  assign result_valid_o  = rvalid_q;
  assign send_request_o  = send_q;
  assign left_capacity_o = left_q;
  assign at_capacity_o   = full_q;
  assign balance_o       = $signed(bal_q);

`include "per_port_token_bucket_table_top_macros.svh"

  `PPTB_ASSERT(a_result_after_work, result_valid_o |-> ($past(state_q == S_TICK) || $past(state_q == S_ITEM)), "result without a finished word")
  `PPTB_ASSERT_NEVER(a_no_write_idle, (state_q == S_IDLE) && ram_we, "slot RAM written while idle")
  `PPTB_ASSERT(a_left_clears_full, (result_valid_o && left_capacity_o) |-> !at_capacity_o, "left capacity with flag still set")
  `PPTB_ASSERT(a_accept_goes_busy, accept |=> busy, "accepted word did not make the block busy")

endmodule

// ----- hw/rtl/pptb_ram.sv -----
// ----------------------------------------------------------------------------
// Token bucket table RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
